[rtl/iir_crossover_filter_macros.svh]
// Assertion macros used by the crossover filter checker.
`ifndef IIR_CROSSOVER_FILTER_MACROS_SVH
`define IIR_CROSSOVER_FILTER_MACROS_SVH

// Require cons in the same cycle as ante.
`define IXF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Require cons in the cycle after ante.
`define IXF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ixf_pkg.sv]
// Types, constants and coefficient helpers for the crossover filter.
`timescale 1ns / 1ps

package ixf_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int OPND_W     = SAMPLE_W + 1;  // room for a negated sample
    localparam int PROD_W     = 56;            // |coef * sample| <= 2^54
    localparam int PSUM_W     = PROD_W + 2;    // sum of three products
    localparam int ACC_W      = PROD_W + 4;    // sum of up to nine products
    localparam int FRAC_SHIFT = 27;
    localparam int ORD_W      = 3;
    localparam int IDX_W      = 3;
    localparam int MODE_W     = 2;

    // Filter mode codes; the unused code behaves as bypass.
    localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SO     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FO     = 2'd2;

    localparam logic [ORD_W-1:0] SO_ORDER = 3'd2;
    localparam logic [ORD_W-1:0] FO_ORDER = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_B0   = 3'd1;
    localparam logic [IDX_W-1:0] REG_B1   = 3'd2;
    localparam logic [IDX_W-1:0] REG_B2   = 3'd3;
    localparam logic [IDX_W-1:0] REG_A1   = 3'd4;
    localparam logic [IDX_W-1:0] REG_A2   = 3'd5;
    localparam logic [IDX_W-1:0] REG_A3   = 3'd6;
    localparam logic [IDX_W-1:0] REG_A4   = 3'd7;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(8388608);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_word_t;
    typedef logic signed [OPND_W-1:0]   opnd_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [PSUM_W-1:0]   psum_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef struct packed {
        coef_word_t b0;
        coef_word_t b1;
        coef_word_t b2;
        coef_word_t a1;
        coef_word_t a2;
        coef_word_t a3;
        coef_word_t a4;
    } coef_t;

    // Per-word control carried down the pipeline.
    typedef struct packed {
        logic             filt;
        logic [ORD_W-1:0] order;
    } ctl_t;

    // Feedforward coefficient of input delay tap n (b3 = b1, b4 = b0).
    function automatic coef_word_t ff_coef(coef_t c, int unsigned tap);
        coef_word_t r;
        case (tap)
            0:       r = c.b1;
            1:       r = c.b2;
            2:       r = c.b1;
            default: r = c.b0;
        endcase
        return r;
    endfunction

    // Feedback coefficient of output delay tap n.
    function automatic coef_word_t fb_coef(coef_t c, int unsigned tap);
        coef_word_t r;
        case (tap)
            0:       r = c.a1;
            1:       r = c.a2;
            2:       r = c.a3;
            default: r = c.a4;
        endcase
        return r;
    endfunction

endpackage

[rtl/ixf_cfg.sv]
// Configuration register file: filter mode and Q4.27 coefficients.
`timescale 1ns / 1ps

module ixf_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [ixf_pkg::IDX_W-1:0]       wr_index,
    input  logic [ixf_pkg::COEF_W-1:0]      wr_data,
    output logic [ixf_pkg::MODE_W-1:0]      mode,
    output ixf_pkg::coef_t                  coef
);
    import ixf_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    coef_t             coef_reg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BYPASS;
            coef_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MODE: mode_reg    <= wr_data[MODE_W-1:0];
                REG_B0:   coef_reg.b0 <= wr_data;
                REG_B1:   coef_reg.b1 <= wr_data;
                REG_B2:   coef_reg.b2 <= wr_data;
                REG_A1:   coef_reg.a1 <= wr_data;
                REG_A2:   coef_reg.a2 <= wr_data;
                REG_A3:   coef_reg.a3 <= wr_data;
                REG_A4:   coef_reg.a4 <= wr_data;
                default:  ;
            endcase
        end
    end

    assign mode = mode_reg;
    assign coef = coef_reg;

endmodule

[rtl/ixf_delay.sv]
// Per-channel input and output delay lines of the direct-form-I filter.
`timescale 1ns / 1ps

module ixf_delay #(
    parameter int CHANNELS  = 2,
    parameter int MAX_ORDER = 4,
    parameter int CH_W      = 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [CH_W-1:0]             rd_cidx,
    output ixf_pkg::sample_t            rd_xd [MAX_ORDER],
    output ixf_pkg::sample_t            rd_yd [MAX_ORDER],
    input  logic                        wr_en,
    input  logic [CH_W-1:0]             wr_cidx,
    input  logic [ixf_pkg::ORD_W-1:0]   wr_order,
    input  ixf_pkg::sample_t            wr_x,
    input  ixf_pkg::sample_t            wr_y
);
    import ixf_pkg::*;

    sample_t xd_reg [CHANNELS][MAX_ORDER];
    sample_t yd_reg [CHANNELS][MAX_ORDER];

    // Shift the active taps of one channel and push the new samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                for (int n = 0; n < MAX_ORDER; n++)
                begin
                    xd_reg[ch][n] <= '0;
                    yd_reg[ch][n] <= '0;
                end
            end
        end
        else if (wr_en)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                if (wr_cidx == CH_W'(ch))
                begin
                    xd_reg[ch][0] <= wr_x;
                    yd_reg[ch][0] <= wr_y;
                    for (int n = 1; n < MAX_ORDER; n++)
                    begin
                        if (ORD_W'(n) < wr_order)
                        begin
                            xd_reg[ch][n] <= xd_reg[ch][n-1];
                            yd_reg[ch][n] <= yd_reg[ch][n-1];
                        end
                    end
                end
            end
        end
    end

    // Select the taps of the channel about to be multiplied
    always_comb
    begin
        for (int n = 0; n < MAX_ORDER; n++)
        begin
            rd_xd[n] = xd_reg[rd_cidx][n];
            rd_yd[n] = yd_reg[rd_cidx][n];
        end
    end

endmodule

[rtl/ixf_mult.sv]
// Product stage: all tap products formed in parallel and registered.
`timescale 1ns / 1ps

module ixf_mult #(
    parameter int MAX_ORDER = 4,
    parameter int NPROD     = 9
)
(
    input  logic                        clk,
    input  logic                        load,
    input  ixf_pkg::sample_t            x,
    input  logic [ixf_pkg::ORD_W-1:0]   order,
    input  ixf_pkg::sample_t            xd [MAX_ORDER],
    input  ixf_pkg::sample_t            yd [MAX_ORDER],
    input  ixf_pkg::coef_t              coef,
    output ixf_pkg::prod_t              prod [NPROD]
);
    import ixf_pkg::*;

    coef_word_t                       coef_sel [NPROD];
    opnd_t                            opnd     [NPROD];
    logic signed [COEF_W+OPND_W-1:0]  full     [NPROD];
    prod_t                            prod_reg [NPROD];

    // Pair each operand with its coefficient; feedback taps use the negated
    // output so that every product is simply added later. Idle taps get zero.
    always_comb
    begin
        coef_sel[0] = coef.b0;
        opnd[0]     = OPND_W'(x);
        for (int n = 0; n < MAX_ORDER; n++)
        begin
            opnd[1+2*n]     = OPND_W'(xd[n]);
            opnd[2+2*n]     = -OPND_W'(yd[n]);
            coef_sel[1+2*n] = (ORD_W'(n) < order) ? ff_coef(coef, n) : '0;
            coef_sel[2+2*n] = (ORD_W'(n) < order) ? fb_coef(coef, n) : '0;
        end
    end

    // One 32 x 25 multiply per tap
    always_comb
    begin
        for (int k = 0; k < NPROD; k++)
        begin
            full[k] = coef_sel[k] * opnd[k];
        end
    end

    // Hold the products for the summing stage
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < NPROD; k++)
            begin
                prod_reg[k] <= full[k][PROD_W-1:0];
            end
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/ixf_acc.sv]
// Summing stage: registered partial sums, then final add, rounding, saturation.
`timescale 1ns / 1ps

module ixf_acc #(
    parameter int NPROD = 9
)
(
    input  logic                clk,
    input  logic                load,
    input  ixf_pkg::prod_t      prod [NPROD],
    output ixf_pkg::sample_t    y
);
    import ixf_pkg::*;

    localparam int NGRP = (NPROD + 2) / 3;

    psum_t psum_next [NGRP];
    psum_t psum_reg  [NGRP];
    acc_t  total;
    acc_t  rnd;
    acc_t  shifted;

    // Add the products in groups of three
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            psum_next[g] = '0;
            for (int j = 0; j < 3; j++)
            begin
                if (3*g + j < NPROD)
                begin
                    psum_next[g] = psum_next[g] + PSUM_W'(prod[3*g+j]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            psum_reg <= psum_next;
        end
    end

    // Add the groups, round half up at bit 27 and clamp to 24 bits
    always_comb
    begin
        total = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total = total + ACC_W'(psum_reg[g]);
        end
        rnd     = total + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
        shifted = rnd >>> FRAC_SHIFT;
        if (shifted > SAT_MAX)
        begin
            y = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            y = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            y = shifted[SAMPLE_W-1:0];
        end
    end

endmodule

[rtl/iir_crossover_filter.sv]
// Top level: two- or four-pole direct-form-I IIR crossover filter per channel, or bypass.
// A result word passes from the input register through the product, partial-sum and
// output registers. In filter modes a word waits in the input register until every
// earlier filtered word on its channel has reached the output register, and
// back-pressure on the output stalls the stages behind it.
// Reset (async, active low) clears the delay lines and coefficients and selects bypass.
`timescale 1ns / 1ps

module iir_crossover_filter #(
    parameter int CHANNELS  = 2,
    parameter int MAX_ORDER = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Sample input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,   // [23:0] sample_in
    input  logic [0:0]                      s_axis_tuser,   // [0] chan
    // Filtered output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,   // [23:0] sample_out
    output logic [0:0]                      m_axis_tuser,   // [0] chan_out
    // Register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ixf_pkg::IDX_W-1:0]       cfg_index,
    input  logic [ixf_pkg::COEF_W-1:0]      cfg_data
);
    import ixf_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NPROD = 1 + 2 * MAX_ORDER;

    logic [MODE_W-1:0] mode;
    coef_t             coef;

    // Input stage
    logic              in_vld_reg, in_vld_next;
    sample_t           in_x_reg;
    logic              in_chan_reg;
    logic [CH_W-1:0]   in_cidx;
    ctl_t              in_ctl;

    // Product stage
    logic              m_vld_reg, m_vld_next;
    sample_t           m_x_reg;
    logic              m_chan_reg;
    logic [CH_W-1:0]   m_cidx_reg;
    ctl_t              m_ctl_reg;

    // Partial-sum stage
    logic              a_vld_reg, a_vld_next;
    sample_t           a_x_reg;
    logic              a_chan_reg;
    logic [CH_W-1:0]   a_cidx_reg;
    ctl_t              a_ctl_reg;

    // Output stage
    logic              o_vld_reg, o_vld_next;
    sample_t           o_data_reg;
    logic              o_chan_reg;

    logic              adv0, adv1, adv2, hazard, in_take;
    sample_t           xd [MAX_ORDER];
    sample_t           yd [MAX_ORDER];
    prod_t             prod [NPROD];
    sample_t           y;

    assign cfg_ready = 1'b1;

    ixf_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .mode     (mode),
        .coef     (coef)
    );

    // Map the channel onto a delay line set and decode the filter order
    always_comb
    begin
        in_cidx      = (CHANNELS > 1) ? CH_W'(in_chan_reg) : CH_W'(0);
        in_ctl.filt  = (mode == MODE_SO) || (mode == MODE_FO);
        in_ctl.order = (mode == MODE_FO) ? FO_ORDER : SO_ORDER;
        if (in_ctl.order > ORD_W'(MAX_ORDER))
        begin
            in_ctl.order = ORD_W'(MAX_ORDER);
        end
    end

    // Stall a word whose channel still has a result on its way to the delay lines
    assign hazard = (m_vld_reg && m_ctl_reg.filt && (m_cidx_reg == in_cidx)) ||
                    (a_vld_reg && a_ctl_reg.filt && (a_cidx_reg == in_cidx));

    assign adv2 = a_vld_reg && (!o_vld_reg || m_axis_tready);
    assign adv1 = m_vld_reg && (!a_vld_reg || adv2);
    assign adv0 = in_vld_reg && (!m_vld_reg || adv1) && !hazard;

    assign s_axis_tready = !in_vld_reg || adv0;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Advance the valid bits
    always_comb
    begin
        in_vld_next = in_take ? 1'b1 : (adv0 ? 1'b0 : in_vld_reg);
        m_vld_next  = adv0 ? 1'b1 : (adv1 ? 1'b0 : m_vld_reg);
        a_vld_next  = adv1 ? 1'b1 : (adv2 ? 1'b0 : a_vld_reg);
        o_vld_next  = adv2 ? 1'b1 : (m_axis_tready ? 1'b0 : o_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            a_vld_reg  <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            m_vld_reg  <= m_vld_next;
            a_vld_reg  <= a_vld_next;
            o_vld_reg  <= o_vld_next;
        end
    end

    // Move word payloads along with their valid bits
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_x_reg    <= s_axis_tdata;
            in_chan_reg <= s_axis_tuser[0];
        end
        if (adv0)
        begin
            m_x_reg    <= in_x_reg;
            m_chan_reg <= in_chan_reg;
            m_cidx_reg <= in_cidx;
            m_ctl_reg  <= in_ctl;
        end
        if (adv1)
        begin
            a_x_reg    <= m_x_reg;
            a_chan_reg <= m_chan_reg;
            a_cidx_reg <= m_cidx_reg;
            a_ctl_reg  <= m_ctl_reg;
        end
        if (adv2)
        begin
            o_data_reg <= a_ctl_reg.filt ? y : a_x_reg;
            o_chan_reg <= a_chan_reg;
        end
    end

    ixf_delay #(
        .CHANNELS  (CHANNELS),
        .MAX_ORDER (MAX_ORDER),
        .CH_W      (CH_W)
    ) u_delay
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_cidx  (in_cidx),
        .rd_xd    (xd),
        .rd_yd    (yd),
        .wr_en    (adv2 && a_ctl_reg.filt),
        .wr_cidx  (a_cidx_reg),
        .wr_order (a_ctl_reg.order),
        .wr_x     (a_x_reg),
        .wr_y     (y)
    );

    ixf_mult #(
        .MAX_ORDER (MAX_ORDER),
        .NPROD     (NPROD)
    ) u_mult
    (
        .clk   (clk),
        .load  (adv0),
        .x     (in_x_reg),
        .order (in_ctl.order),
        .xd    (xd),
        .yd    (yd),
        .coef  (coef),
        .prod  (prod)
    );

    ixf_acc #(
        .NPROD (NPROD)
    ) u_acc
    (
        .clk  (clk),
        .load (adv1),
        .prod (prod),
        .y    (y)
    );

    assign m_axis_tvalid   = o_vld_reg;
    assign m_axis_tdata    = o_data_reg;
    assign m_axis_tuser[0] = o_chan_reg;

endmodule

[rtl/ixf_checker.sv]
// Port-level checker for the crossover filter, bound to the top level.
`timescale 1ns / 1ps
`include "iir_crossover_filter_macros.svh"

module ixf_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [23:0] sample_out
    input  logic [0:0]  m_axis_tuser    // [0] chan_out
);

    logic [2:0] cnt_reg, cnt_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Track words accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg + 3'(in_acc) - 3'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `IXF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
    `IXF_ASSERT_NOW(a_no_invent, m_axis_tvalid, cnt_reg != 3'd0, "output word without an accepted input word")
    `IXF_ASSERT_NOW(a_depth, 1'b1, cnt_reg <= 3'd4, "more words in flight than pipeline stages")
    `IXF_ASSERT_NOW(a_empty_ready, cnt_reg == 3'd0, s_axis_tready, "empty pipeline refuses input")

endmodule

bind iir_crossover_filter ixf_checker u_ixf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
